@@ hw/rtl/bcs_pkg.sv @@
// Package: shared types and constants of the breath cycle sequencer.
package bcs_pkg;

  localparam int unsigned MsPerMinute = 60000;

  typedef enum logic [1:0] {
    PH_ACT  = 2'd0,
    PH_EXH  = 2'd1,
    PH_INSP = 2'd2,
    PH_BAD  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_CTRL = 2'd1,
    K_TRIG = 2'd2,
    K_RSVD = 2'd3
  } kind_e;

  localparam logic [2:0] REG_RATE  = 3'd0;
  localparam logic [2:0] REG_TI    = 3'd1;
  localparam logic [2:0] REG_VOL   = 3'd2;
  localparam logic [2:0] REG_VMODE = 3'd3;
  localparam logic [2:0] REG_SEN   = 3'd4;
  localparam logic [2:0] REG_SPER  = 3'd5;
  localparam logic [2:0] REG_SCOEF = 3'd6;

  typedef struct packed {
    logic activate;
    logic clear_sigh_count;
    logic trigger_seen;
    logic high_pressure;
    logic trigger_off;
    logic adjust_busy;
  } in_t;

  typedef struct packed {
    logic [1:0]  insp_kind;
    logic        sigh_flag;
    logic [1:0]  phase;
    logic [15:0] measured_ti;
    logic [15:0] measured_te;
    logic [12:0] active_ti;
    logic [12:0] active_volume;
  } out_t;

  typedef struct packed {
    logic [5:0]  breath_rate;
    logic [11:0] insp_time_ms;
    logic [10:0] tidal_volume;
    logic        volume_mode;
    logic        sigh_enable;
    logic [7:0]  sigh_period;
    logic [4:0]  sigh_coef;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start;   // begin arithmetic for the latched item
    logic step;    // apply the step, update state
  } cmd_t;

  typedef struct packed {
    logic done;    // arithmetic results ready
  } sts_t;

endpackage

@@ hw/rtl/bcs_if.sv @@
// Interfaces: valid/ready channels for input and result items.
interface bcs_in_if;
  logic           valid;
  logic           ready;
  bcs_pkg::in_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcs_out_if;
  logic           valid;
  logic           ready;
  bcs_pkg::out_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bcs_div.sv @@
// Restoring divider: one quotient bit per cycle.
module bcs_div #(
  parameter int unsigned NumW = 17,
  parameter int unsigned DenW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quot_o,
  output logic            done_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
      quot_d = {quot_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      // Flag the cycle in which the last quotient bit sits in quot_q.
      done_q <= busy_q && (cnt_q == CntW'(1)) && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;
endmodule

@@ hw/rtl/bcs_ctrl.sv @@
// Controller: sequences accept, arithmetic, state update and result hand-off.
module bcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bcs_pkg::cmd_t     cmd_o,
  input  bcs_pkg::sts_t     sts_i
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_STEP = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = S_CALC;
        end
      end
      S_CALC: if (sts_i.done) state_d = S_STEP;
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule

@@ hw/rtl/bcs_dp.sv @@
// Datapath: breath state, period division, sigh scaling and result register.
module bcs_dp #(
  parameter int unsigned CounterBits = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [11:0]    cfg_data_i,
  input  bcs_pkg::in_t   in_i,
  input  bcs_pkg::cmd_t  cmd_i,
  output bcs_pkg::sts_t  sts_o,
  output bcs_pkg::out_t  out_o
);
  localparam logic [CounterBits-1:0] CntMax = '1;

  bcs_pkg::cfg_t   cfg_q;
  bcs_pkg::in_t    in_q;
  bcs_pkg::out_t   out_q;
  bcs_pkg::phase_e phase_q;
  bcs_pkg::kind_e  last_kind_q;
  logic            exh_done_q, saved_toff_q, lock_q;
  logic [15:0]     te_target_q, ti_meas_q, te_meas_q;
  logic [CounterBits-1:0] te_cnt_q, ti_cnt_q;
  logic [7:0]      sigh_cnt_q;
  logic [12:0]     eff_ti_q, eff_vol_q;

  // Precomputed products, registered before use.
  logic [15:0]     period_q;
  logic [21:0]     sigh_te_prod_q;
  logic [16:0]     ti_prod_q;
  logic [15:0]     vol_prod_q;
  logic [1:0]      calc_q;
  logic            div_done;
  logic [16:0]     quot;
  logic [5:0]      rate_eff;

  assign rate_eff = (cfg_q.breath_rate == '0) ? 6'd1 : cfg_q.breath_rate;

  bcs_div #(.NumW(17), .DenW(6)) u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.start),
    .num_i   (17'(bcs_pkg::MsPerMinute)),
    .den_i   (rate_eff),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // After division: period, then product by coef, then /10 by reciprocal
  // multiplication in the following cycle.
  logic [17:0] q_ti, q_vol, q_te;
  // Divide by 10 via multiply by 1677722 >> 24 (exact for values < 2^22).
  function automatic logic [17:0] div10(input logic [21:0] v);
    logic [42:0] p;
    p = 43'(v) * 43'd1677722;
    return 18'(p >> 24);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) calc_q <= '0;
    else if (cmd_i.start) calc_q <= '0;
    else if (div_done) calc_q <= 2'd1;
    else if (calc_q == 2'd1) calc_q <= 2'd2;
    else if (calc_q == 2'd2) calc_q <= 2'd3;
  end

  always_ff @(posedge clk_i) begin
    if (div_done) period_q <= quot[15:0];
    if (calc_q == 2'd1) begin
      sigh_te_prod_q <= 22'(period_q) * 22'(cfg_q.sigh_coef);
      ti_prod_q      <= 17'(cfg_q.insp_time_ms) * 17'(cfg_q.sigh_coef);
      vol_prod_q     <= 16'(cfg_q.tidal_volume) * 16'(cfg_q.sigh_coef);
    end
    if (calc_q == 2'd2) begin
      q_te  <= div10(sigh_te_prod_q);
      q_ti  <= div10(22'(ti_prod_q));
      q_vol <= div10(22'(vol_prod_q));
    end
    if (cmd_i.start) in_q <= in_i;
  end

  assign sts_o.done = (calc_q == 2'd3) && !cmd_i.step;

  function automatic logic [15:0] subsat(input logic [16:0] a, input logic [16:0] b);
    return (a > b) ? 16'(a - b) : 16'd0;
  endfunction
  function automatic logic [15:0] sat16(input logic [CounterBits-1:0] v);
    return (v > CounterBits'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction
  function automatic logic [12:0] sat13(input logic [17:0] v);
    return (v > 18'd8191) ? 13'h1FFF : 13'(v);
  endfunction

  // Step combinational logic.
  bcs_pkg::phase_e ph, ph_d;
  bcs_pkg::kind_e  kind, last_kind_d;
  logic            sigh, exh_d, toff_d, lock_d, trig, sdo, sclr;
  logic [15:0]     tet_d, tim_d, tem_d, te_sigh;
  logic [CounterBits-1:0] tec_d, tic_d;
  logic [7:0]      sc, sc_d, lim;
  logic [12:0]     eti_d, evol_d;

  always_comb begin
    ph = in_q.activate ? bcs_pkg::PH_ACT : phase_q;
    sc = in_q.clear_sigh_count ? 8'd0 : sigh_cnt_q;
    ph_d = ph; kind = bcs_pkg::K_NONE; last_kind_d = last_kind_q;
    sigh = 1'b0; exh_d = exh_done_q; toff_d = saved_toff_q; lock_d = lock_q;
    tet_d = te_target_q; tim_d = ti_meas_q; tem_d = te_meas_q;
    tec_d = te_cnt_q; tic_d = ti_cnt_q; sc_d = sc;
    eti_d = eff_ti_q; evol_d = eff_vol_q; trig = 1'b0; sdo = 1'b0; sclr = 1'b0;
    lim = (cfg_q.sigh_period == 8'd0) ? 8'd0 : cfg_q.sigh_period - 8'd1;
    te_sigh = (q_te > 18'h0FFFF) ? 16'hFFFF : 16'(q_te);
    case (ph)
      bcs_pkg::PH_ACT: begin
        lock_d = 1'b0;
        tet_d = subsat(17'(period_q), 17'(eff_ti_q));
        if (!exh_done_q) begin
          tec_d = '0;
          ph_d = bcs_pkg::PH_EXH;
        end else begin
          sdo = 1'b1;
          tic_d = '0;
          kind = bcs_pkg::K_CTRL; last_kind_d = bcs_pkg::K_CTRL;
          eti_d = 13'(cfg_q.insp_time_ms); evol_d = 13'(cfg_q.tidal_volume);
          ph_d = bcs_pkg::PH_INSP;
        end
      end
      bcs_pkg::PH_EXH: begin
        if (in_q.high_pressure) tet_d = subsat(17'(period_q), 17'(ti_meas_q));
        if (in_q.trigger_off)      trig = 1'b0;
        else if (in_q.adjust_busy) trig = !saved_toff_q && in_q.trigger_seen;
        else                       trig = in_q.trigger_seen;
        if (trig) begin
          kind = bcs_pkg::K_TRIG; last_kind_d = bcs_pkg::K_TRIG; exh_d = 1'b1;
        end else if (te_cnt_q >= CounterBits'(tet_d)) begin
          kind = bcs_pkg::K_CTRL; last_kind_d = bcs_pkg::K_CTRL; exh_d = 1'b1;
        end
        if (!in_q.adjust_busy) toff_d = in_q.trigger_off;
        if (exh_d) begin
          sdo = 1'b1; sclr = 1'b1;
          tem_d = sat16(te_cnt_q);
          tic_d = '0;
          eti_d = 13'(cfg_q.insp_time_ms); evol_d = 13'(cfg_q.tidal_volume);
          ph_d = bcs_pkg::PH_INSP;
        end
      end
      bcs_pkg::PH_INSP: begin
        if (CounterBits'(ti_cnt_q) >= CounterBits'(eff_ti_q) || in_q.high_pressure) begin
          tim_d = sat16(ti_cnt_q);
          tec_d = '0; exh_d = 1'b0; ph_d = bcs_pkg::PH_EXH;
        end else begin
          kind = last_kind_q;
        end
      end
      default: begin
        lock_d = 1'b0; ph_d = bcs_pkg::PH_EXH;
      end
    endcase
    if (sdo) begin
      if (cfg_q.sigh_enable && cfg_q.volume_mode) begin
        if (sc >= lim) begin
          sc_d = 8'd0; sigh = 1'b1;
          if (sclr) lock_d = 1'b0;
        end else begin
          sc_d = sc + 8'd1;
        end
      end else if (sclr) begin
        sc_d = 8'd0;
      end
    end
    if (sclr) begin
      if (sigh && cfg_q.volume_mode)
        tet_d = subsat(17'(te_sigh), {4'd0, cfg_q.insp_time_ms, 1'b0});
      else
        tet_d = subsat(17'(period_q), 17'(cfg_q.insp_time_ms));
      if (sigh && cfg_q.volume_mode && !lock_d) begin
        lock_d = 1'b1;
        eti_d = sat13(q_ti); evol_d = sat13(q_vol);
      end
    end
    if (tec_d != CntMax) tec_d = tec_d + 1'b1;
    if (tic_d != CntMax) tic_d = tic_d + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{breath_rate: 6'd15, insp_time_ms: 12'd1000, tidal_volume: 11'd500,
                 volume_mode: 1'b0, sigh_enable: 1'b0, sigh_period: 8'd50,
                 sigh_coef: 5'd15};
      phase_q <= bcs_pkg::PH_EXH; last_kind_q <= bcs_pkg::K_NONE;
      exh_done_q <= 1'b0; saved_toff_q <= 1'b0; lock_q <= 1'b0;
      te_target_q <= '0; ti_meas_q <= '0; te_meas_q <= '0;
      te_cnt_q <= '0; ti_cnt_q <= '0; sigh_cnt_q <= '0;
      eff_ti_q <= 13'd1000; eff_vol_q <= 13'd500;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bcs_pkg::REG_RATE:  cfg_q.breath_rate  <= cfg_data_i[5:0];
          bcs_pkg::REG_TI:    cfg_q.insp_time_ms <= cfg_data_i[11:0];
          bcs_pkg::REG_VOL:   cfg_q.tidal_volume <= cfg_data_i[10:0];
          bcs_pkg::REG_VMODE: cfg_q.volume_mode  <= cfg_data_i[0];
          bcs_pkg::REG_SEN:   cfg_q.sigh_enable  <= cfg_data_i[0];
          bcs_pkg::REG_SPER:  cfg_q.sigh_period  <= cfg_data_i[7:0];
          bcs_pkg::REG_SCOEF: cfg_q.sigh_coef    <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        phase_q <= ph_d; last_kind_q <= last_kind_d;
        exh_done_q <= exh_d; saved_toff_q <= toff_d; lock_q <= lock_d;
        te_target_q <= tet_d; ti_meas_q <= tim_d; te_meas_q <= tem_d;
        te_cnt_q <= tec_d; ti_cnt_q <= tic_d; sigh_cnt_q <= sc_d;
        eff_ti_q <= eti_d; eff_vol_q <= evol_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.insp_kind     <= kind;
      out_q.sigh_flag     <= sigh;
      out_q.phase         <= ph_d;
      out_q.measured_ti   <= tim_d;
      out_q.measured_te   <= tem_d;
      out_q.active_ti     <= eti_d;
      out_q.active_volume <= evol_d;
    end
  end

  assign out_o = out_q;
endmodule

@@ hw/rtl/breath_cycle_sequencer_top.sv @@
// Top level: breath cycle sequencer, one result per accepted tick.
// Sequence from accept to result valid: the restoring period divider, capture of
// the period, sigh scaling (product, then divide by ten), the controller cycle
// that sees the arithmetic done, and the step that updates state; then waits
// for out ready. A new tick is accepted only after the previous result is taken.
// Reset (rst_ni low, async): control and config regs reset; data regs do not.
module breath_cycle_sequencer_top #(
  parameter int unsigned CounterBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  bcs_in_if.sink      in_if,
  bcs_out_if.source   out_if
);
  bcs_pkg::cmd_t cmd;
  bcs_pkg::sts_t sts;

  bcs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bcs_dp #(.CounterBits(CounterBits)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i  (in_if.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_if.data)
  );
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench of the breath cycle sequencer: predicted tick results checked against the block.
module tb;

  localparam int unsigned CntMax = 65535;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [11:0] cfg_data_i;

  bcs_in_if  in_ch ();
  bcs_out_if out_ch ();

  breath_cycle_sequencer_top u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Predictor state and settings.
  bcs_pkg::cfg_t   cfg;
  bcs_pkg::phase_e ph;
  logic        exh_done;
  int unsigned te_tgt, te_cnt, ti_cnt;
  logic [7:0]  sigh_cnt;
  bcs_pkg::kind_e  prev_kind;
  logic        saved_toff, lock;
  int unsigned eff_ti, eff_vol, ti_meas, te_meas;

  bcs_pkg::out_t tick_q[$];
  int          fails;
  int          cycles;
  logic        quiet;
  logic        hold_long;

  function automatic int unsigned breath_ms();
    int unsigned r;
    r = (cfg.breath_rate == 0) ? 1 : cfg.breath_rate;
    return bcs_pkg::MsPerMinute / r;
  endfunction

  function automatic int unsigned sub0(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int unsigned sigh_scale(int unsigned v);
    int unsigned s;
    s = (v * cfg.sigh_coef) / 10;
    return (s > 8191) ? 8191 : s;
  endfunction

  function automatic logic take_sigh(logic clr_off, logic clr_lock);
    int unsigned lim;
    if (cfg.sigh_enable && cfg.volume_mode) begin
      lim = (cfg.sigh_period == 0) ? 0 : cfg.sigh_period - 1;
      if (sigh_cnt >= lim) begin
        sigh_cnt = 0;
        if (clr_lock) lock = 1'b0;
        return 1'b1;
      end
      sigh_cnt = sigh_cnt + 8'd1;
      return 1'b0;
    end
    if (clr_off) sigh_cnt = 0;
    return 1'b0;
  endfunction

  function automatic void predictor_reset();
    cfg = '{breath_rate: 15, insp_time_ms: 1000, tidal_volume: 500, volume_mode: 0,
            sigh_enable: 0, sigh_period: 50, sigh_coef: 15};
    ph = bcs_pkg::PH_EXH; exh_done = 0; te_tgt = 0; te_cnt = 0; ti_cnt = 0; sigh_cnt = 0;
    prev_kind = bcs_pkg::K_NONE; saved_toff = 0; lock = 0;
    eff_ti = 1000; eff_vol = 500; ti_meas = 0; te_meas = 0;
  endfunction

  function automatic bcs_pkg::out_t next_tick(bcs_pkg::in_t t);
    bcs_pkg::out_t o;
    bcs_pkg::kind_e k;
    logic s, trig;
    int unsigned p;
    k = bcs_pkg::K_NONE; s = 0;
    if (t.activate) ph = bcs_pkg::PH_ACT;
    if (t.clear_sigh_count) sigh_cnt = 0;
    case (ph)
      bcs_pkg::PH_ACT: begin
        lock = 0;
        te_tgt = sub0(breath_ms(), eff_ti);
        if (!exh_done) begin
          te_cnt = 0; ph = bcs_pkg::PH_EXH;
        end else begin
          s = take_sigh(1'b0, 1'b0);
          ti_cnt = 0; k = bcs_pkg::K_CTRL; prev_kind = bcs_pkg::K_CTRL;
          eff_ti = cfg.insp_time_ms; eff_vol = cfg.tidal_volume;
          ph = bcs_pkg::PH_INSP;
        end
      end
      bcs_pkg::PH_EXH: begin
        if (t.high_pressure) te_tgt = sub0(breath_ms(), ti_meas);
        if (t.trigger_off) trig = 0;
        else if (t.adjust_busy) trig = !saved_toff && t.trigger_seen;
        else trig = t.trigger_seen;
        if (trig) begin
          k = bcs_pkg::K_TRIG; prev_kind = bcs_pkg::K_TRIG; exh_done = 1;
        end else if (te_cnt >= te_tgt) begin
          k = bcs_pkg::K_CTRL; prev_kind = bcs_pkg::K_CTRL; exh_done = 1;
        end
        if (!t.adjust_busy) saved_toff = t.trigger_off;
        if (exh_done) begin
          s = take_sigh(1'b1, 1'b1);
          te_meas = te_cnt;
          ti_cnt = 0;
          eff_ti = cfg.insp_time_ms; eff_vol = cfg.tidal_volume;
          if (s && cfg.volume_mode) begin
            p = breath_ms() * cfg.sigh_coef / 10;
            if (p > 65535) p = 65535;
            te_tgt = sub0(p, cfg.insp_time_ms * 2);
          end else begin
            te_tgt = sub0(breath_ms(), cfg.insp_time_ms);
          end
          if (s && cfg.volume_mode && !lock) begin
            lock = 1;
            eff_ti = sigh_scale(cfg.insp_time_ms);
            eff_vol = sigh_scale(cfg.tidal_volume);
          end
          ph = bcs_pkg::PH_INSP;
        end
      end
      bcs_pkg::PH_INSP: begin
        if (ti_cnt >= eff_ti || t.high_pressure) begin
          ti_meas = ti_cnt; te_cnt = 0; exh_done = 0; ph = bcs_pkg::PH_EXH;
        end else begin
          k = prev_kind;
        end
      end
      default: begin
        lock = 0; ph = bcs_pkg::PH_EXH;
      end
    endcase
    if (te_cnt < CntMax) te_cnt++;
    if (ti_cnt < CntMax) ti_cnt++;
    o.insp_kind = k; o.sigh_flag = s; o.phase = ph;
    o.measured_ti = ti_meas; o.measured_te = te_meas;
    o.active_ti = eff_ti; o.active_volume = eff_vol;
    return o;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  // Hold the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[11:0];
    @(posedge clk_i);
    case (idx)
      bcs_pkg::REG_RATE:  cfg.breath_rate  = val[5:0];
      bcs_pkg::REG_TI:    cfg.insp_time_ms = val[11:0];
      bcs_pkg::REG_VOL:   cfg.tidal_volume = val[10:0];
      bcs_pkg::REG_VMODE: cfg.volume_mode  = val[0];
      bcs_pkg::REG_SEN:   cfg.sigh_enable  = val[0];
      bcs_pkg::REG_SPER:  cfg.sigh_period  = val[7:0];
      bcs_pkg::REG_SCOEF: cfg.sigh_coef    = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (tick_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Send one transaction; predicted result goes to the queue on acceptance.
  task automatic send_tick(bcs_pkg::in_t t, logic gaps);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tick_q.push_back(next_tick(t));
  endtask

  // Output side: compare every accepted transaction against the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (tick_q.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        bcs_pkg::out_t w, g;
        w = tick_q.pop_front();
        g = out_ch.data;
        if (g.insp_kind != w.insp_kind) report("insp_kind", g.insp_kind, w.insp_kind);
        if (g.sigh_flag != w.sigh_flag) report("sigh_flag", g.sigh_flag, w.sigh_flag);
        if (g.phase != w.phase) report("phase", g.phase, w.phase);
        if (g.measured_ti != w.measured_ti)
          report("measured_ti", g.measured_ti, w.measured_ti);
        if (g.measured_te != w.measured_te)
          report("measured_te", g.measured_te, w.measured_te);
        if (g.active_ti != w.active_ti) report("active_ti", g.active_ti, w.active_ti);
        if (g.active_volume != w.active_volume)
          report("active_volume", g.active_volume, w.active_volume);
      end
    end
  end

  // Output ready: random stalls plus one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed rows: expected phase given where obvious (-1 means predictor only).
  typedef struct {
    bcs_pkg::in_t tk;
    int  want_phase;
  } row_t;

  bcs_pkg::in_t  t;
  row_t rows[$];
  bcs_pkg::out_t chk;

  initial begin
    fails = 0; quiet = 0; hold_long = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    predictor_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Target Te is 0 after reset: first tick ends exhalation as controlled breath.
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, bcs_pkg::PH_INSP});
    rows.push_back('{'{0, 0, 0, 1, 0, 0}, bcs_pkg::PH_EXH});   // high pressure ends insp
    rows.push_back('{'{0, 0, 1, 0, 0, 0}, bcs_pkg::PH_INSP});  // triggered breath
    rows.push_back('{'{1, 0, 0, 0, 0, 0}, bcs_pkg::PH_INSP});  // activate after exhale done
    rows.push_back('{'{0, 0, 0, 1, 0, 0}, bcs_pkg::PH_EXH});
    rows.push_back('{'{1, 1, 0, 0, 0, 0}, bcs_pkg::PH_EXH});   // activate, exhale not done
    rows.push_back('{'{0, 0, 1, 1, 1, 0}, -1});       // trigger off masks trigger
    rows.push_back('{'{0, 0, 1, 0, 0, 1}, -1});       // busy, saved trigger off
    rows.push_back('{'{0, 0, 1, 1, 1, 1}, -1});
    rows.push_back('{'{0, 1, 1, 0, 0, 1}, -1});
    rows.push_back('{'{1, 1, 1, 1, 1, 1}, bcs_pkg::PH_EXH});
    rows.push_back('{'{0, 0, 1, 0, 0, 0}, -1});
    foreach (rows[i]) begin
      send_tick(rows[i].tk, 1'b0);
      chk = tick_q[$];
      if (rows[i].want_phase >= 0 && chk.phase != rows[i].want_phase)
        report("directed phase", chk.phase, rows[i].want_phase);
    end
    in_ch.valid <= 1'b0;
    drain();

    // Extremes: sigh every breath, max coef, fast rate; then slow rate and min values.
    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      case (ph_i)
        0: begin
          write_reg(bcs_pkg::REG_RATE, 60); write_reg(bcs_pkg::REG_TI, 4095);
          write_reg(bcs_pkg::REG_VOL, 2047); write_reg(bcs_pkg::REG_VMODE, 1);
          write_reg(bcs_pkg::REG_SEN, 1); write_reg(bcs_pkg::REG_SPER, 0);
          write_reg(bcs_pkg::REG_SCOEF, 31);
        end
        1: begin
          write_reg(bcs_pkg::REG_RATE, 0); write_reg(bcs_pkg::REG_TI, 100);
          write_reg(bcs_pkg::REG_VOL, 50); write_reg(bcs_pkg::REG_SPER, 1);
          write_reg(bcs_pkg::REG_SCOEF, 25);
        end
        2: begin
          write_reg(bcs_pkg::REG_RATE, 60); write_reg(bcs_pkg::REG_TI, 12);
          write_reg(bcs_pkg::REG_SPER, 3); write_reg(bcs_pkg::REG_SCOEF, 10);
        end
        3: begin
          write_reg(bcs_pkg::REG_RATE, 63); write_reg(bcs_pkg::REG_TI, 5);
          write_reg(bcs_pkg::REG_SEN, 0); write_reg(bcs_pkg::REG_VMODE, 0);
          write_reg(bcs_pkg::REG_SPER, 255); write_reg(bcs_pkg::REG_SCOEF, 0);
        end
        4: begin
          write_reg(bcs_pkg::REG_RATE, 50); write_reg(bcs_pkg::REG_TI, 8);
          write_reg(bcs_pkg::REG_VMODE, 1); write_reg(bcs_pkg::REG_SEN, 1);
          write_reg(bcs_pkg::REG_SPER, 2); write_reg(bcs_pkg::REG_SCOEF, 15);
          write_reg(bcs_pkg::REG_VOL, 1000); write_reg(7, 1234);
        end
        5: begin
          write_reg(bcs_pkg::REG_RATE, 61); write_reg(bcs_pkg::REG_TI, 3);
          hold_long = 1'b1;
        end
        6: begin
          write_reg(bcs_pkg::REG_RATE, 40); write_reg(bcs_pkg::REG_TI, 20);
          write_reg(bcs_pkg::REG_SCOEF, 20);
        end
        default: begin
          write_reg(bcs_pkg::REG_RATE, 55); write_reg(bcs_pkg::REG_TI, 6);
          quiet = 1'b1;
        end
      endcase
      cfg_we_i <= 1'b0;
      for (int n = 0; n < 225; n++) begin
        // Mostly clean ticks; alarms and activations stay rare.
        t.activate = ($urandom_range(0, 40) == 0);
        t.clear_sigh_count = ($urandom_range(0, 30) == 0);
        t.high_pressure = ($urandom_range(0, 15) == 0);
        t.trigger_seen = ($urandom_range(0, 6) == 0);
        t.trigger_off = ($urandom_range(0, 5) == 0);
        t.adjust_busy = ($urandom_range(0, 4) == 0);
        send_tick(t, 1'b1);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_if.sv
hw/rtl/bcs_div.sv
hw/rtl/bcs_ctrl.sv
hw/rtl/bcs_dp.sv
hw/rtl/breath_cycle_sequencer_top.sv
sim/tb.sv
